// ===== hw/rtl/rsc_pkg.sv =====
package rsc_pkg;

  localparam int WORD_BITS   = 64;
  localparam int MAX_WORDS   = 64;
  localparam int WIDX_W      = 6;
  localparam int MAX_DEPTH   = 16;
  localparam int LVL_W       = 5;
  localparam int STK_LVL_W   = 4;
  localparam int LIM_W       = 7;
  localparam int MAX_ATTRS   = 128;
  localparam int ATTR_W      = 7;
  localparam int MAX_CLASSES = 4;
  localparam int CLS_W       = 2;
  localparam int CNT_W       = 13;
  localparam int PC_W        = 7;
  localparam int STK_AW      = STK_LVL_W + WIDX_W;
  localparam int ATTR_AW     = ATTR_W + WIDX_W;

  localparam logic [2:0] OP_LOAD_ATTR  = 3'd0;
  localparam logic [2:0] OP_LOAD_CLASS = 3'd1;
  localparam logic [2:0] OP_ISECT_POS  = 3'd2;
  localparam logic [2:0] OP_ISECT_NEG  = 3'd3;
  localparam logic [2:0] OP_BACKTRACK  = 3'd4;
  localparam logic [2:0] OP_RESTART    = 3'd5;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DEPTH = 2'd1;
  localparam logic [1:0] ERR_ROOT  = 2'd2;

  localparam logic CFG_NUM_TRANS   = 1'b0;
  localparam logic CFG_NUM_CLASSES = 1'b1;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [ATTR_W-1:0]    attr_index;
    logic [WIDX_W-1:0]    word_index;
    logic [CLS_W-1:0]     class_index;
    logic [WORD_BITS-1:0] word_bits;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] total_support;
    logic [CNT_W-1:0] class_support_0;
    logic [CNT_W-1:0] class_support_1;
    logic [CNT_W-1:0] class_support_2;
    logic [CNT_W-1:0] class_support_3;
    logic [LVL_W-1:0] depth;
    logic [LIM_W-1:0] live_words;
    logic [1:0]       error;
  } res_t;

  typedef struct packed {
    logic [STK_AW-1:0]    ord_raddr;
    logic [STK_AW-1:0]    cov_raddr;
    logic [ATTR_AW-1:0]   attr_raddr;
    logic [WIDX_W-1:0]    cls_raddr;
    logic                 cov_we;
    logic [STK_AW-1:0]    cov_waddr;
    logic [WORD_BITS-1:0] cov_wdata;
    logic                 ord_we;
    logic [STK_AW-1:0]    ord_waddr;
    logic [WIDX_W-1:0]    ord_wdata;
    logic                 attr_we;
    logic [ATTR_AW-1:0]   attr_waddr;
    logic                 cls_we;
    logic [CLS_W-1:0]     cls_sel;
    logic [WIDX_W-1:0]    cls_waddr;
    logic [WORD_BITS-1:0] load_wdata;
  } mem_req_t;

  typedef struct packed {
    logic [WIDX_W-1:0]                      ord_q;
    logic [WORD_BITS-1:0]                   cov_q;
    logic [WORD_BITS-1:0]                   attr_q;
    logic [MAX_CLASSES-1:0][WORD_BITS-1:0]  cls_q;
  } mem_rsp_t;

  function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
    logic [PC_W-1:0] c;
    c = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      c = c + PC_W'(v[k]);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/reversible_sparse_cover_engine_core.sv =====
// Channel   Ports                                  Beat taken when
// command   start, busy, cmd                       start && !busy
// result    done, result                           done (one cycle)
// config    cfg_we, cfg_index, cfg_data            cfg_we
//
// Loads, backtrack and restart walk the live words of the level reached;
// intersect walks the live words of the source level and writes the next.
// In the memory sequencer each word goes through order read, word reads,
// combine and count. Synchronous reset; no clearing pass: level 0 is implied
// by the last restart. The result receiver cannot stall; busy holds off new
// commands.
module reversible_sparse_cover_engine_core
  import rsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cmd_t             cmd,
  output logic             busy,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             done,
  output res_t             result
);

  mem_req_t req;
  mem_rsp_t rsp;

  rsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp       (rsp),
    .req       (req),
    .busy      (busy),
    .done      (done),
    .result    (result)
  );

  rsc_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== hw/rtl/rsc_store.sv =====
module rsc_store
  import rsc_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  logic [WORD_BITS-1:0] attr_mem [0:(1<<ATTR_AW)-1];
  logic [WORD_BITS-1:0] cls_mem  [0:MAX_CLASSES-1][0:MAX_WORDS-1];
  logic [WORD_BITS-1:0] cov_mem  [0:(1<<STK_AW)-1];
  logic [WIDX_W-1:0]    ord_mem  [0:(1<<STK_AW)-1];

  // attribute covers
  always_ff @(posedge clk) begin
    if (req.attr_we) begin
      attr_mem[req.attr_waddr] <= req.load_wdata;
    end
    rsp.attr_q <= attr_mem[req.attr_raddr];
  end

  // class covers, one bank per class
  always_ff @(posedge clk) begin
    if (req.cls_we) begin
      cls_mem[req.cls_sel][req.cls_waddr] <= req.load_wdata;
    end
    for (int j = 0; j < MAX_CLASSES; j++) begin
      rsp.cls_q[j] <= cls_mem[j][req.cls_raddr];
    end
  end

  // cover stack, levels 1 and up
  always_ff @(posedge clk) begin
    if (req.cov_we) begin
      cov_mem[req.cov_waddr] <= req.cov_wdata;
    end
    rsp.cov_q <= cov_mem[req.cov_raddr];
  end

  // live word order, levels 1 and up
  always_ff @(posedge clk) begin
    if (req.ord_we) begin
      ord_mem[req.ord_waddr] <= req.ord_wdata;
    end
    rsp.ord_q <= ord_mem[req.ord_raddr];
  end

endmodule

// ===== hw/rtl/rsc_ctrl.sv =====
module rsc_ctrl
  import rsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cmd_t             cmd,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  mem_rsp_t         rsp,
  output mem_req_t         req,
  output logic             busy,
  output logic             done,
  output res_t             result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ORD  = 3'd1;
  localparam logic [2:0] S_WRD  = 3'd2;
  localparam logic [2:0] S_AND  = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state;
  logic [LVL_W-1:0]       level;
  logic [LIM_W-1:0]       limit [0:MAX_DEPTH];
  logic [WIDX_W-1:0]      rem;
  logic [CNT_W-1:0]       num_trans;
  logic [2:0]             num_cls;
  logic [LVL_W-1:0]       lvl;
  logic [LIM_W-1:0]       lim;
  logic [LIM_W-1:0]       i;
  logic [LIM_W-1:0]       f;
  logic [LIM_W-1:0]       b;
  logic                   is_isect;
  logic                   pos;
  logic [ATTR_W-1:0]      attr;
  logic [1:0]             err;
  logic [WIDX_W-1:0]      w;
  logic [WORD_BITS-1:0]   v;
  logic [MAX_CLASSES-1:0][WORD_BITS-1:0] cv;
  logic [CNT_W-1:0]       acc_total;
  logic [MAX_CLASSES-1:0][CNT_W-1:0] acc_cs;

  logic                   accept;
  logic [13:0]            nw_sum;
  logic [7:0]             nw_raw;
  logic [LIM_W-1:0]       nw;
  logic [LVL_W-1:0]       lvl_next;
  logic [LIM_W-1:0]       lim_next;
  logic [LVL_W-1:0]       lm1;
  logic [LVL_W-1:0]       lp1;
  logic [WIDX_W-1:0]      wsel;
  logic [WORD_BITS-1:0]   cur;
  logic [WORD_BITS-1:0]   a;
  logic [WORD_BITS-1:0]   v_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // word count for a restart, saturated
  assign nw_sum = {1'b0, num_trans} + 14'd63;
  assign nw_raw = nw_sum[13:6];
  assign nw     = (nw_raw > 8'(MAX_WORDS)) ? LIM_W'(MAX_WORDS) : nw_raw[LIM_W-1:0];

  // level and live count that the pass works on
  always_comb begin
    lvl_next = level;
    if (cmd.opcode == OP_BACKTRACK && level != '0) begin
      lvl_next = level - 1'b1;
    end else if (cmd.opcode == OP_RESTART) begin
      lvl_next = '0;
    end
    lim_next = (cmd.opcode == OP_RESTART) ? nw : limit[lvl_next];
  end

  assign lm1  = lvl - 1'b1;
  assign lp1  = lvl + 1'b1;
  assign wsel = (lvl == '0) ? i[WIDX_W-1:0] : rsp.ord_q;

  // level 0 cover is implied by the last restart
  always_comb begin
    if (lvl == '0) begin
      cur = (w == '0 && rem != '0) ? ~({WORD_BITS{1'b1}} << rem) : {WORD_BITS{1'b1}};
    end else begin
      cur = rsp.cov_q;
    end
    a      = pos ? rsp.attr_q : ~rsp.attr_q;
    v_next = is_isect ? (cur & a) : cur;
  end

  // memory requests
  always_comb begin
    req            = '0;
    req.ord_raddr  = {lm1[STK_LVL_W-1:0], i[WIDX_W-1:0]};
    req.cov_raddr  = {lm1[STK_LVL_W-1:0], wsel};
    req.attr_raddr = {attr, wsel};
    req.cls_raddr  = wsel;
    req.cov_waddr  = {lvl[STK_LVL_W-1:0], w};
    req.cov_wdata  = v_next;
    req.ord_waddr  = {lvl[STK_LVL_W-1:0],
                      (v_next != '0) ? f[WIDX_W-1:0] : b[WIDX_W-1:0]};
    req.ord_wdata  = w;
    req.attr_waddr = {cmd.attr_index, cmd.word_index};
    req.cls_sel    = cmd.class_index;
    req.cls_waddr  = cmd.word_index;
    req.load_wdata = cmd.word_bits;
    req.attr_we    = accept && cmd.opcode == OP_LOAD_ATTR;
    req.cls_we     = accept && cmd.opcode == OP_LOAD_CLASS;
    req.cov_we     = (state == S_AND) && is_isect;
    req.ord_we     = (state == S_AND) && is_isect;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_trans <= CNT_W'(4096);
      num_cls   <= 3'd2;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NUM_TRANS) begin
        num_trans <= cfg_data;
      end else begin
        num_cls <= cfg_data[2:0];
      end
    end
  end

  // sequencer: per live word read order, read words, combine, count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      level    <= '0;
      limit[0] <= LIM_W'(MAX_WORDS);
      rem      <= '0;
      done     <= 1'b0;
      is_isect <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_isect  <= 1'b0;
            err       <= ERR_NONE;
            pos       <= (cmd.opcode == OP_ISECT_POS);
            attr      <= cmd.attr_index;
            lvl       <= lvl_next;
            lim       <= lim_next;
            i         <= '0;
            f         <= '0;
            b         <= lim_next - 1'b1;
            acc_total <= '0;
            acc_cs    <= '0;
            case (cmd.opcode)
              OP_ISECT_POS, OP_ISECT_NEG: begin
                if (level >= LVL_W'(MAX_DEPTH)) begin
                  err <= ERR_DEPTH;
                end else begin
                  is_isect <= 1'b1;
                end
              end
              OP_BACKTRACK: begin
                if (level == '0) begin
                  err <= ERR_ROOT;
                end else begin
                  level <= lvl_next;
                end
              end
              OP_RESTART: begin
                level    <= '0;
                limit[0] <= nw;
                rem      <= num_trans[WIDX_W-1:0];
              end
              default: begin
              end
            endcase
            state <= S_ORD;
          end
        end
        S_ORD: begin
          state <= (i == lim) ? S_FIN : S_WRD;
        end
        S_WRD: begin
          w     <= wsel;
          state <= S_AND;
        end
        S_AND: begin
          v  <= v_next;
          cv <= rsp.cls_q;
          if (is_isect) begin
            if (v_next != '0) begin
              f <= f + 1'b1;
            end else begin
              b <= b - 1'b1;
            end
          end
          state <= S_CNT;
        end
        S_CNT: begin
          acc_total <= acc_total + CNT_W'(popcount(v));
          for (int j = 0; j < MAX_CLASSES; j++) begin
            acc_cs[j] <= acc_cs[j] + CNT_W'(popcount(v & cv[j]));
          end
          i     <= i + 1'b1;
          state <= S_ORD;
        end
        S_FIN: begin
          result.total_support   <= acc_total;
          result.class_support_0 <= (num_cls > 3'd0) ? acc_cs[0] : '0;
          result.class_support_1 <= (num_cls > 3'd1) ? acc_cs[1] : '0;
          result.class_support_2 <= (num_cls > 3'd2) ? acc_cs[2] : '0;
          result.class_support_3 <= (num_cls > 3'd3) ? acc_cs[3] : '0;
          result.error           <= err;
          if (is_isect) begin
            level             <= lp1;
            limit[lp1]        <= f;
            result.depth      <= lp1;
            result.live_words <= f;
          end else begin
            result.depth      <= lvl;
            result.live_words <= lim;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
      level <= LVL_W'(MAX_DEPTH))
    else $error("level beyond stack depth");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
      state == S_ORD |-> i <= lim)
    else $error("word walk past live range");
  // modulo the count width, since b wraps once every word is emptied
  a_split_count: assert property (@(posedge clk) disable iff (rst)
      (state == S_ORD && is_isect && lim != '0) |->
      (LIM_W'(f + lim) == LIM_W'(i + b + LIM_W'(1))))
    else $error("survivor and emptied counts disagree with walk");
  a_restart_root: assert property (@(posedge clk) disable iff (rst)
      (accept && cmd.opcode == OP_RESTART) |=> level == '0)
    else $error("restart did not return to root");

endmodule

// ===== test/rsc_checker.sv =====
`timescale 1ns / 100ps

module rsc_checker
  import rsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  cmd_t             cmd,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             done,
  input  res_t             result,
  output int               errors,
  output int               pending,
  output int               n_results
);

  // Shadow copy of the engine state
  bit [WORD_BITS-1:0] attr_cov [MAX_ATTRS*MAX_WORDS];
  bit [WORD_BITS-1:0] class_cov [MAX_CLASSES*MAX_WORDS];
  bit [WORD_BITS-1:0] level_cov [(MAX_DEPTH+1)*MAX_WORDS];
  bit [WIDX_W-1:0]    word_order [MAX_WORDS];
  int                 live_cnt [MAX_DEPTH+1];
  int                 cur_level;
  bit [CNT_W-1:0]     n_trans;
  bit [2:0]           n_classes;

  res_t support_q[$];

  assign pending = support_q.size();

  // Rebuild level 0 as the full cover for the current transaction count
  task automatic rebuild_cover();
    int nw;
    int rem;
    nw  = (int'(n_trans) + WORD_BITS - 1) / WORD_BITS;
    rem = int'(n_trans) % WORD_BITS;
    if (nw > MAX_WORDS) nw = MAX_WORDS;
    for (int i = 0; i < MAX_WORDS; i++) begin
      level_cov[i]  = '1;
      word_order[i] = WIDX_W'(i);
    end
    if (nw > 0 && rem != 0) level_cov[0] = (64'd1 << rem) - 64'd1;
    live_cnt[0] = nw;
    cur_level   = 0;
  endtask

  // AND live words with an attribute cover (or its complement) into next level
  task automatic narrow_cover(int attr, bit positive);
    int lim;
    int base;
    int i;
    int w;
    bit [WORD_BITS-1:0] a;
    bit [WORD_BITS-1:0] v;
    lim  = live_cnt[cur_level];
    base = cur_level * MAX_WORDS;
    i    = 0;
    while (i < lim) begin
      w = word_order[i];
      a = attr_cov[attr*MAX_WORDS + w];
      if (!positive) a = ~a;
      v = level_cov[base + w] & a;
      level_cov[base + MAX_WORDS + w] = v;
      if (v == '0) begin
        word_order[i]       = word_order[lim-1];
        word_order[lim-1]   = WIDX_W'(w);
        lim--;
      end else begin
        i++;
      end
    end
    cur_level++;
    live_cnt[cur_level] = lim;
  endtask

  // Apply one command beat and compute the supports it reports
  task automatic apply_cmd(input cmd_t c, output res_t r);
    int ncl;
    int lim;
    int base;
    int w;
    int tot;
    int cs[4];
    logic [1:0] err;
    err = ERR_NONE;
    ncl = (n_classes > MAX_CLASSES) ? MAX_CLASSES : int'(n_classes);
    case (c.opcode)
      OP_LOAD_ATTR:  attr_cov[c.attr_index*MAX_WORDS + c.word_index] = c.word_bits;
      OP_LOAD_CLASS: class_cov[c.class_index*MAX_WORDS + c.word_index] = c.word_bits;
      OP_ISECT_POS, OP_ISECT_NEG: begin
        if (cur_level >= MAX_DEPTH) err = ERR_DEPTH;
        else narrow_cover(int'(c.attr_index), c.opcode == OP_ISECT_POS);
      end
      OP_BACKTRACK: begin
        if (cur_level == 0) err = ERR_ROOT;
        else cur_level--;
      end
      OP_RESTART: rebuild_cover();
      default: ;
    endcase
    tot  = 0;
    cs   = '{0, 0, 0, 0};
    lim  = live_cnt[cur_level];
    base = cur_level * MAX_WORDS;
    for (int i = 0; i < lim; i++) begin
      w = word_order[i];
      tot += $countones(level_cov[base + w]);
      for (int j = 0; j < ncl; j++)
        cs[j] += $countones(level_cov[base + w] & class_cov[j*MAX_WORDS + w]);
    end
    r.total_support   = CNT_W'(tot);
    r.class_support_0 = CNT_W'(cs[0]);
    r.class_support_1 = CNT_W'(cs[1]);
    r.class_support_2 = CNT_W'(cs[2]);
    r.class_support_3 = CNT_W'(cs[3]);
    r.depth           = LVL_W'(cur_level);
    r.live_words      = LIM_W'(lim);
    r.error           = err;
  endtask

  // Field-by-field compare of one result beat
  task automatic compare_result(input res_t exp_r, input res_t got_r);
    int ev[8];
    int gv[8];
    string nm[8];
    nm = '{"total_support", "class_support_0", "class_support_1", "class_support_2",
           "class_support_3", "depth", "live_words", "error"};
    ev = '{exp_r.total_support, exp_r.class_support_0, exp_r.class_support_1,
           exp_r.class_support_2, exp_r.class_support_3, exp_r.depth,
           exp_r.live_words, exp_r.error};
    gv = '{got_r.total_support, got_r.class_support_0, got_r.class_support_1,
           got_r.class_support_2, got_r.class_support_3, got_r.depth,
           got_r.live_words, got_r.error};
    for (int k = 0; k < 8; k++) begin
      if ($isunknown(got_r) || ev[k] != gv[k]) begin
        $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, nm[k], ev[k], gv[k]);
        errors++;
      end
    end
  endtask

  // Watch config, command and result channels
  always @(posedge clk) begin
    res_t r;
    if (rst) begin
      n_trans   = 13'd4096;
      n_classes = 3'd2;
      rebuild_cover();
      support_q.delete();
      errors    = 0;
      n_results = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_TRANS) n_trans = cfg_data;
        else n_classes = cfg_data[2:0];
      end
      if (start && !busy) begin
        apply_cmd(cmd, r);
        support_q.insert(support_q.size(), r);
      end
      if (done) begin
        n_results++;
        if (support_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %p", $time, result);
          errors++;
        end else begin
          compare_result(support_q.pop_front(), result);
        end
      end
    end
  end

endmodule

// ===== test/tb_reversible_sparse_cover_engine_core.sv =====
`timescale 1ns / 100ps

module tb_reversible_sparse_cover_engine_core;
  import rsc_pkg::*;

  localparam int  CYCLE_LIMIT   = 3000000;
  localparam int  RAND_PER_SET  = 128;
  localparam int  N_SETS        = 9;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  cmd_t             cmd = '0;
  logic             busy;
  logic             cfg_we = 1'b0;
  logic             cfg_index = 1'b0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             done;
  res_t             result;

  int errors;
  int pending;
  int n_results;
  int cycles = 0;
  int n_sent = 0;
  int idle_pct = 0;
  int dive_left = 0;
  int rand_sent = 0;

  reversible_sparse_cover_engine_core u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  rsc_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result(result),
    .errors(errors), .pending(pending), .n_results(n_results)
  );

  always #6 clk = ~clk;

  // Timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [2:0] op, int attr, int widx, int cls,
                              logic [WORD_BITS-1:0] bits);
    cmd_t c;
    c.opcode      = op;
    c.attr_index  = ATTR_W'(attr);
    c.word_index  = WIDX_W'(widx);
    c.class_index = CLS_W'(cls);
    c.word_bits   = bits;
    return c;
  endfunction

  // Mixed densities so intersects also empty words
  function automatic logic [WORD_BITS-1:0] rand_word();
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return a;
      1: return a & b;
      2: return a & b & {$urandom, $urandom} & {$urandom, $urandom};
      3: return $urandom_range(1) ? '1 : '0;
      default: return a | b;
    endcase
  endfunction

  // Attributes whose covers are fully loaded: 0..3 and 124..127
  function automatic int pick_attr();
    int k;
    k = $urandom_range(7);
    return (k < 4) ? k : 120 + k;
  endfunction

  // Drive one command beat; returns at the edge that takes it
  task automatic send(cmd_t c);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0 && !busy) break;
    end
    repeat (4) @(posedge clk);
  endtask

  // Both registers, written back to back while idle, then a restart
  task automatic set_regs(int ntr, int ncl);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_TRANS;
    cfg_data  <= CNT_W'(ntr);
    @(posedge clk);
    cfg_index <= CFG_NUM_CLASSES;
    cfg_data  <= CNT_W'(ncl);
    @(posedge clk);
    cfg_we    <= 1'b0;
    send(mk(OP_RESTART, 0, 0, 0, '0));
  endtask

  task automatic send_random();
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (dive_left > 0) begin
      dive_left--;
      r = 10;
    end
    if (r < 40) begin
      op = $urandom_range(1) ? OP_ISECT_POS : OP_ISECT_NEG;
      send(mk(op, pick_attr(), $urandom_range(63), $urandom_range(3), rand_word()));
    end else if (r < 68) begin
      send(mk(OP_BACKTRACK, $urandom_range(127), $urandom_range(63), $urandom_range(3),
              rand_word()));
    end else if (r < 78) begin
      send(mk(OP_LOAD_ATTR, $urandom_range(127), $urandom_range(63), $urandom_range(3),
              rand_word()));
    end else if (r < 86) begin
      send(mk(OP_LOAD_CLASS, $urandom_range(127), $urandom_range(63), $urandom_range(3),
              rand_word()));
    end else if (r < 91) begin
      send(mk(OP_RESTART, $urandom_range(127), $urandom_range(63), 0, rand_word()));
    end else if (r < 95) begin
      op = $urandom_range(1) ? 3'd6 : 3'd7;
      send(mk(op, $urandom_range(127), $urandom_range(63), $urandom_range(3), rand_word()));
    end else begin
      // deep run of intersects to reach the depth limit
      dive_left = 18;
      send(mk(OP_ISECT_NEG, pick_attr(), 0, 0, '0));
    end
    rand_sent++;
    idle_pct = (rand_sent < 384) ? 6 : (rand_sent < 768) ? 55 : 0;
  endtask

  initial begin
    int set_ntr[N_SETS];
    int set_ncl[N_SETS];
    set_ntr = '{4096, 1, 64, 65, 4095, 8191, 0, 100, 0};
    set_ncl = '{4, 1, 2, 3, 4, 7, 0, 5, 0};
    set_ntr[8] = $urandom_range(1, 4096);
    set_ncl[8] = $urandom_range(1, 4);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty cover first so no unwritten class or attribute word is read
    set_regs(0, 4);
    for (int c = 0; c < MAX_CLASSES; c++)
      for (int w = 0; w < MAX_WORDS; w++)
        send(mk(OP_LOAD_CLASS, 0, w, c, rand_word()));
    for (int k = 0; k < 8; k++)
      for (int w = 0; w < MAX_WORDS; w++)
        send(mk(OP_LOAD_ATTR, (k < 4) ? k : 120 + k, w, 0, rand_word()));

    // Directed: each operation, field extremes, root backtrack, unknown opcodes
    set_regs(4096, 4);
    send(mk(OP_ISECT_POS, 0, 0, 0, '0));
    send(mk(OP_ISECT_NEG, 127, 63, 3, '1));
    send(mk(OP_ISECT_POS, 124, 0, 0, '0));
    send(mk(OP_BACKTRACK, 0, 0, 0, '0));
    send(mk(OP_BACKTRACK, 0, 0, 0, '0));
    send(mk(OP_BACKTRACK, 0, 0, 0, '0));
    send(mk(OP_BACKTRACK, 127, 63, 3, '1));
    send(mk(3'd6, 0, 0, 0, '0));
    send(mk(3'd7, 127, 63, 3, '1));
    send(mk(OP_LOAD_ATTR, 127, 63, 0, '1));
    send(mk(OP_LOAD_ATTR, 0, 0, 0, '0));
    send(mk(OP_LOAD_CLASS, 0, 63, 3, '0));
    send(mk(OP_LOAD_CLASS, 127, 0, 0, '1));
    send(mk(OP_ISECT_NEG, 0, 0, 0, '0));
    send(mk(OP_RESTART, 127, 63, 3, '1));

    // Random part across several register settings
    idle_pct = 6;
    for (int s = 0; s < N_SETS; s++) begin
      set_regs(set_ntr[s], set_ncl[s]);
      for (int i = 0; i < RAND_PER_SET; i++) send_random();
    end

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Sent %0d command beats (%0d random) over %0d register settings; %0d results",
             n_sent, rand_sent, N_SETS + 2, n_results);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rsc_pkg.sv
hw/rtl/rsc_store.sv
hw/rtl/rsc_ctrl.sv
hw/rtl/reversible_sparse_cover_engine_core.sv
test/rsc_checker.sv
test/tb_reversible_sparse_cover_engine_core.sv
